>>> rtl/core/lfpd_pkg.sv
`default_nettype none

package lfpd_pkg;

  // Sensor row and position arithmetic
  localparam int unsigned NumSensors = 5;
  localparam int unsigned SensorW    = 5;
  localparam int unsigned WeightStep = 1000;
  localparam int unsigned CenterPos  = 3000;
  // Weighted sum holds up to 1000 * (1 + 2 + ... + 5)
  localparam int unsigned WsumW      = 14;
  localparam int unsigned CntW       = 3;
  localparam int unsigned ErrW       = 12;
  localparam int unsigned GainW      = 24;
  localparam int unsigned SpeedW     = 8;
  localparam int unsigned DutyW      = 16;

  // Divider retires two quotient bits per cycle
  localparam int unsigned DivSteps   = WsumW / 2;
  localparam int unsigned DivCntW    = 3;

  // Configuration port
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 24;

  localparam logic [CfgIdxW-1:0] CfgGainProp  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGainDeriv = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBaseLeft  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgBaseRight = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMaxLeft   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgMaxRight  = 3'd5;

  typedef struct packed {
    logic [GainW-1:0]  gain_prop;
    logic [GainW-1:0]  gain_deriv;
    logic [SpeedW-1:0] base_left;
    logic [SpeedW-1:0] base_right;
    logic [SpeedW-1:0] max_left;
    logic [SpeedW-1:0] max_right;
  } cfg_t;

  // Controller to datapath strobes
  typedef struct packed {
    logic load;
    logic div_step;
    logic err_en;
    logic mul_en;
    logic sum_en;
    logic drv_en;
    logic out_load;
  } cmd_t;

  // speed * 65534 / 255 truncated: 65534 = 257*255 - 1, so for speed in 1..255
  // the quotient is speed*257 - 1, and speed*257 is the byte repeated.
  function automatic logic [DutyW-1:0] speed_to_duty(input logic [SpeedW-1:0] s);
    logic [DutyW-1:0] rep;
    rep = {s, s};
    if (s == '0) begin
      return '0;
    end
    return rep - DutyW'(1);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/line_follower_pd_drive_core.sv
`default_nettype none

// Line follower PD drive: one beat of five line-sensor bits in, one beat of
// left/right PWM duty, line-found flag and tracking error out. An accepted
// beat passes a restoring divider (two quotient bits a cycle) that forms the
// line position, then registered steps for error, the two gain multiplies,
// their sum, the Q16 drop and the speed clamp into the output register. A new
// beat is taken the cycle after the result is loaded, not before; a result
// that waits in the output register does not hold back the next computation
// until it reaches its final load. Gains and speeds are to be written through
// the configuration port while the block is idle; the block itself does not
// enforce this.
module line_follower_pd_drive_core
  import lfpd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [SensorW-1:0]  sensor_bits_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [DutyW-1:0]         duty_left_o,
  output logic [DutyW-1:0]         duty_right_o,
  output logic                     line_found_o,
  output logic signed [ErrW-1:0]   track_error_o
);

  cfg_t cfg;
  cmd_t cmd;

  lfpd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lfpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  lfpd_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg),
    .sensor_bits_i (sensor_bits_i),
    .duty_left_o   (duty_left_o),
    .duty_right_o  (duty_right_o),
    .line_found_o  (line_found_o),
    .track_error_o (track_error_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/lfpd_cfg.sv
`default_nettype none

module lfpd_cfg
  import lfpd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q;

  // Decode the register index and drop value bits beyond each register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_prop  <= GainW'(3932);
      cfg_q.gain_deriv <= GainW'(78643);
      cfg_q.base_left  <= SpeedW'(120);
      cfg_q.base_right <= SpeedW'(120);
      cfg_q.max_left   <= SpeedW'(180);
      cfg_q.max_right  <= SpeedW'(180);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgGainProp:  cfg_q.gain_prop  <= cfg_data_i[GainW-1:0];
        CfgGainDeriv: cfg_q.gain_deriv <= cfg_data_i[GainW-1:0];
        CfgBaseLeft:  cfg_q.base_left  <= cfg_data_i[SpeedW-1:0];
        CfgBaseRight: cfg_q.base_right <= cfg_data_i[SpeedW-1:0];
        CfgMaxLeft:   cfg_q.max_left   <= cfg_data_i[SpeedW-1:0];
        CfgMaxRight:  cfg_q.max_right  <= cfg_data_i[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/core/lfpd_ctrl.sv
`default_nettype none

module lfpd_ctrl
  import lfpd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_ERR  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_DRV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [DivCntW-1:0] step_q, step_d;
  logic               out_valid_q, out_valid_d;
  logic               in_fire;
  logic               out_free;
  logic               div_last;

  assign in_fire  = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign div_last = (step_q == DivCntW'(DivSteps - 1));

  // Datapath strobes follow the state
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = in_fire;
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.err_en   = (state_q == S_ERR);
    cmd_o.mul_en   = (state_q == S_MUL);
    cmd_o.sum_en   = (state_q == S_SUM);
    cmd_o.drv_en   = (state_q == S_DRV);
    cmd_o.out_load = (state_q == S_OUT) && out_free;
  end

  // Sequence one beat through divide, error, multiply, sum, drive and output
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      S_IDLE: begin
        step_d = '0;
        if (in_fire) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        step_d = step_q + DivCntW'(1);
        if (div_last) begin
          state_d = S_ERR;
        end
      end
      S_ERR: state_d = S_MUL;
      S_MUL: state_d = S_SUM;
      S_SUM: state_d = S_DRV;
      S_DRV: state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the result beat until the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_DIV) && (step_q == '0))
    else $error("accepted beat did not start the divider");

  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a stalled beat");

  a_valid_rise_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.out_load))
    else $error("result valid without a load");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ERR) |-> ($past(state_q) == S_DIV) && ($past(div_last)))
    else $error("divider left early");
`endif

endmodule

`default_nettype wire

>>> rtl/core/lfpd_dpath.sv
`default_nettype none

module lfpd_dpath
  import lfpd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  cmd_t                     cmd_i,
  input  cfg_t                     cfg_i,
  input  wire logic [SensorW-1:0]  sensor_bits_i,
  output logic [DutyW-1:0]         duty_left_o,
  output logic [DutyW-1:0]         duty_right_o,
  output logic                     line_found_o,
  output logic signed [ErrW-1:0]   track_error_o
);

  localparam int unsigned NumUsed    = (NumSensors < SensorW) ? NumSensors : SensorW;
  localparam int unsigned WideW      = WsumW + 1;
  localparam int unsigned DerW       = ErrW + 1;
  localparam int unsigned ProdPW     = ErrW + GainW + 1;
  localparam int unsigned ProdDW     = DerW + GainW + 1;
  localparam int unsigned AccW       = ProdDW + 1;
  localparam int unsigned DriveShift = 16;
  localparam int unsigned DriveW     = AccW - DriveShift;
  localparam int unsigned SpdW       = DriveW + 2;

  localparam logic signed [WideW-1:0] ErrHi     = WideW'(2 ** (ErrW - 1) - 1);
  localparam logic signed [WideW-1:0] ErrLo     = ~ErrHi;
  localparam logic signed [AccW-1:0]  RoundBias = AccW'((1 << DriveShift) - 1);

  logic [WsumW-1:0]           wsum;
  logic [CntW-1:0]            cnt;
  logic [WsumW-1:0]           quo_q, quo_n;
  logic [CntW-1:0]            rem_q, rem_n;
  logic [CntW-1:0]            dvs_q;
  logic                       found_q;
  logic [CntW:0]              trial;
  logic                       qbit;
  logic signed [WideW-1:0]    err_wide;
  logic signed [ErrW-1:0]     err_sat, err_sel;
  logic signed [ErrW-1:0]     err_q, prev_err_q;
  logic signed [DerW-1:0]     deriv_q;
  logic signed [ProdPW-1:0]   prod_p_q;
  logic signed [ProdDW-1:0]   prod_d_q;
  logic signed [AccW-1:0]     acc_q;
  logic [AccW-1:0]            acc_rnd;
  logic signed [DriveW-1:0]   drive_q;
  logic signed [SpdW-1:0]     spd_l, spd_r;
  logic signed [SpdW-1:0]     max_l, max_r;
  logic [SpeedW-1:0]          clip_l, clip_r;
  logic [DutyW-1:0]           duty_l_q, duty_r_q;
  logic                       found_out_q;
  logic signed [ErrW-1:0]     err_out_q;

  // Weight and count the active sensors of the incoming beat
  always_comb begin
    wsum = '0;
    cnt  = '0;
    for (int k = 0; k < NumUsed; k++) begin
      if (sensor_bits_i[k]) begin
        wsum = wsum + WsumW'((k + 1) * WeightStep);
        cnt  = cnt + CntW'(1);
      end
    end
  end

  // Restoring divide, two quotient bits per step
  always_comb begin
    rem_n = rem_q;
    quo_n = quo_q;
    trial = '0;
    qbit  = 1'b0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_n, quo_n[WsumW-1]};
      qbit  = (trial >= {1'b0, dvs_q});
      if (qbit) begin
        rem_n = CntW'(trial - {1'b0, dvs_q});
      end else begin
        rem_n = CntW'(trial);
      end
      quo_n = {quo_n[WsumW-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      quo_q   <= wsum;
      rem_q   <= '0;
      dvs_q   <= cnt;
      found_q <= (cnt != '0) && (cnt != CntW'(NumSensors));
    end else if (cmd_i.div_step) begin
      quo_q <= quo_n;
      rem_q <= rem_n;
    end
  end

  // Error from the quotient, saturated, or the held value when no line
  always_comb begin
    err_wide = $signed(WideW'(CenterPos) - {1'b0, quo_q});
    if (err_wide > ErrHi) begin
      err_sat = ErrHi[ErrW-1:0];
    end else if (err_wide < ErrLo) begin
      err_sat = ErrLo[ErrW-1:0];
    end else begin
      err_sat = err_wide[ErrW-1:0];
    end
    err_sel = found_q ? err_sat : prev_err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
    end else if (cmd_i.err_en) begin
      prev_err_q <= err_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.err_en) begin
      err_q   <= err_sel;
      deriv_q <= DerW'(err_sel) - DerW'(prev_err_q);
    end
  end

  // Gain products, one multiplier each, registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_p_q <= err_q * $signed({1'b0, cfg_i.gain_prop});
      prod_d_q <= deriv_q * $signed({1'b0, cfg_i.gain_deriv});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      acc_q <= AccW'(prod_p_q) + AccW'(prod_d_q);
    end
  end

  // Drop the Q16 fraction, rounding toward zero
  assign acc_rnd = acc_q + (acc_q[AccW-1] ? RoundBias : '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.drv_en) begin
      drive_q <= $signed(acc_rnd[AccW-1:DriveShift]);
    end
  end

  // Wheel speeds, clamped to zero and their maximum
  always_comb begin
    spd_l = SpdW'($signed({1'b0, cfg_i.base_left}))  + SpdW'(drive_q);
    spd_r = SpdW'($signed({1'b0, cfg_i.base_right})) - SpdW'(drive_q);
    max_l = $signed(SpdW'({1'b0, cfg_i.max_left}));
    max_r = $signed(SpdW'({1'b0, cfg_i.max_right}));
    if (spd_l > max_l) begin
      clip_l = cfg_i.max_left;
    end else if (spd_l < 0) begin
      clip_l = '0;
    end else begin
      clip_l = spd_l[SpeedW-1:0];
    end
    if (spd_r > max_r) begin
      clip_r = cfg_i.max_right;
    end else if (spd_r < 0) begin
      clip_r = '0;
    end else begin
      clip_r = spd_r[SpeedW-1:0];
    end
  end

  // Load the whole result beat together so it holds while stalled
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      duty_l_q    <= speed_to_duty(clip_l);
      duty_r_q    <= speed_to_duty(clip_r);
      found_out_q <= found_q;
      err_out_q   <= err_q;
    end
  end

  assign duty_left_o   = duty_l_q;
  assign duty_right_o  = duty_r_q;
  assign line_found_o  = found_out_q;
  assign track_error_o = err_out_q;

endmodule

`default_nettype wire
